FILE: rtl/core/two_level_inclusive_lru_cache_core_assert.svh
// Assertion macros used by the cache core controller.
`ifndef TWO_LEVEL_INCLUSIVE_LRU_CACHE_CORE_ASSERT_SVH
`define TWO_LEVEL_INCLUSIVE_LRU_CACHE_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define TLC_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);
`define TLC_ASSERT_NR(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);
`else
`define TLC_ASSERT(lbl, ck, rs, prop, msg)
`define TLC_ASSERT_NR(lbl, ck, prop, msg)
`endif
`endif

FILE: rtl/core/tlc_pkg.sv
package tlc_pkg;

  localparam int L1_MAX_SET_BITS = 6;
  localparam int L1_MAX_WAY_BITS = 2;
  localparam int L2_MAX_SET_BITS = 8;
  localparam int L2_MAX_WAY_BITS = 3;
  localparam int ADDR_BITS       = 32;
  localparam int MAX_OFFSET_BITS = 10;
  localparam int CNT_W           = 32;

  localparam int L1_WAYS = 1 << L1_MAX_WAY_BITS;
  localparam int L2_WAYS = 1 << L2_MAX_WAY_BITS;
  localparam int L1_SETS = 1 << L1_MAX_SET_BITS;
  localparam int L2_SETS = 1 << L2_MAX_SET_BITS;

  // configuration register indexes
  localparam logic [2:0] CFG_BLOCK_OFFSET = 3'd0;
  localparam logic [2:0] CFG_L1_SETS      = 3'd1;
  localparam logic [2:0] CFG_L1_WAYS      = 3'd2;
  localparam logic [2:0] CFG_L2_SETS      = 3'd3;
  localparam logic [2:0] CFG_L2_WAYS      = 3'd4;
  localparam logic [2:0] CFG_WRITE_ALLOC  = 3'd5;

  typedef struct packed {
    logic                 command;
    logic [ADDR_BITS-1:0] address;
  } access_t;

  typedef struct packed {
    logic             l1_hit;
    logic             l2_accessed;
    logic             l2_hit;
    logic             memory_accessed;
    logic [CNT_W-1:0] l1_access_total;
    logic [CNT_W-1:0] l1_miss_total;
    logic [CNT_W-1:0] l2_access_total;
    logic [CNT_W-1:0] l2_miss_total;
  } result_t;

  typedef struct packed {
    logic clear;    // write reset rows at the sweep index
    logic take;     // latch the accepted item
    logic rd_main;  // read both levels at the item's sets
    logic lookup;   // hit check, counters, L1 hit / L2 update
    logic rd_bi;    // read L1 at the L2 victim's set
    logic do_bi;    // back-invalidate L1 copy
    logic rd_v1;    // re-read L1 at the item's set
    logic do_v1;    // L1 fill
    logic rd_wb;    // read L2 at the dirty L1 victim's set
    logic do_wb;    // mark L2 copy dirty and promote
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic l1_hit;
    logic l2_hit;
    logic fill;
    logic l2_vic_valid;
    logic l1_vic_dirty;
  } status_t;

endpackage

FILE: rtl/core/tlc_ram.sv
module tlc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/tlc_datapath.sv
module tlc_datapath (
  input  logic                clk,
  input  logic                rst,
  input  tlc_pkg::access_t    access,
  input  tlc_pkg::cmd_t       cmd,
  output tlc_pkg::status_t    status,
  output tlc_pkg::result_t    result,
  input  logic                cfg_valid,
  input  logic [2:0]          cfg_index,
  input  logic [3:0]          cfg_data
);

  localparam int AW  = tlc_pkg::ADDR_BITS;
  localparam int S1W = tlc_pkg::L1_MAX_SET_BITS;
  localparam int S2W = tlc_pkg::L2_MAX_SET_BITS;
  localparam int R1W = tlc_pkg::L1_MAX_WAY_BITS;
  localparam int R2W = tlc_pkg::L2_MAX_WAY_BITS;

  typedef struct packed {
    logic [AW-1:0]  tag;
    logic           valid;
    logic           dirty;
    logic [R1W-1:0] rank;
  } l1_ent_t;
  typedef l1_ent_t [tlc_pkg::L1_WAYS-1:0] l1_row_t;

  typedef struct packed {
    logic [AW-1:0]  tag;
    logic           valid;
    logic           dirty;
    logic [R2W-1:0] rank;
  } l2_ent_t;
  typedef l2_ent_t [tlc_pkg::L2_WAYS-1:0] l2_row_t;

  // ---- helpers ----
  function automatic logic [R1W:0] l1_find(l1_row_t r, logic [AW-1:0] tag, logic [1:0] wb);
    logic [R1W:0] res;
    res = '0;
    for (int w = tlc_pkg::L1_WAYS - 1; w >= 0; w--) begin
      if (w < (1 << wb) && r[w].valid && r[w].tag == tag) res = {1'b1, R1W'(w)};
    end
    return res;
  endfunction

  function automatic logic [R2W:0] l2_find(l2_row_t r, logic [AW-1:0] tag, logic [1:0] wb);
    logic [R2W:0] res;
    res = '0;
    for (int w = tlc_pkg::L2_WAYS - 1; w >= 0; w--) begin
      if (w < (1 << wb) && r[w].valid && r[w].tag == tag) res = {1'b1, R2W'(w)};
    end
    return res;
  endfunction

  // lowest way holding rank 0, way 0 if none
  function automatic logic [R1W-1:0] l1_victim(l1_row_t r, logic [1:0] wb);
    logic [R1W-1:0] res;
    res = '0;
    for (int w = tlc_pkg::L1_WAYS - 1; w >= 0; w--) begin
      if (w < (1 << wb) && r[w].rank == '0) res = R1W'(w);
    end
    return res;
  endfunction

  function automatic logic [R2W-1:0] l2_victim(l2_row_t r, logic [1:0] wb);
    logic [R2W-1:0] res;
    res = '0;
    for (int w = tlc_pkg::L2_WAYS - 1; w >= 0; w--) begin
      if (w < (1 << wb) && r[w].rank == '0) res = R2W'(w);
    end
    return res;
  endfunction

  function automatic l1_row_t l1_touch(l1_row_t r, logic [R1W-1:0] way, logic [1:0] wb);
    l1_row_t        o;
    logic [R1W-1:0] old;
    int             n;
    o   = r;
    old = r[way].rank;
    n   = 1 << wb;
    for (int w = 0; w < tlc_pkg::L1_WAYS; w++) begin
      if (w < n) begin
        if (R1W'(w) == way) o[w].rank = R1W'(n - 1);
        else if (r[w].rank > old) o[w].rank = r[w].rank - 1'b1;
      end
    end
    return o;
  endfunction

  function automatic l2_row_t l2_touch(l2_row_t r, logic [R2W-1:0] way, logic [1:0] wb);
    l2_row_t        o;
    logic [R2W-1:0] old;
    int             n;
    o   = r;
    old = r[way].rank;
    n   = 1 << wb;
    for (int w = 0; w < tlc_pkg::L2_WAYS; w++) begin
      if (w < n) begin
        if (R2W'(w) == way) o[w].rank = R2W'(n - 1);
        else if (r[w].rank > old) o[w].rank = r[w].rank - 1'b1;
      end
    end
    return o;
  endfunction

  // ---- configuration ----
  logic [3:0] block_offset_bits;
  logic [2:0] l1_set_bits;
  logic [1:0] l1_way_bits;
  logic [3:0] l2_set_bits;
  logic [1:0] l2_way_bits;
  logic       write_allocate;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_offset_bits <= 4'd4;
      l1_set_bits       <= 3'd6;
      l1_way_bits       <= 2'd1;
      l2_set_bits       <= 4'd8;
      l2_way_bits       <= 2'd2;
      write_allocate    <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        tlc_pkg::CFG_BLOCK_OFFSET: block_offset_bits <= cfg_data;
        tlc_pkg::CFG_L1_SETS:      l1_set_bits       <= cfg_data[2:0];
        tlc_pkg::CFG_L1_WAYS:      l1_way_bits       <= cfg_data[1:0];
        tlc_pkg::CFG_L2_SETS:      l2_set_bits       <= cfg_data;
        tlc_pkg::CFG_L2_WAYS:      l2_way_bits       <= cfg_data[1:0];
        tlc_pkg::CFG_WRITE_ALLOC:  write_allocate    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [3:0] off;
  logic [2:0] s1;
  logic [1:0] w1;
  logic [3:0] s2;
  logic [1:0] w2;

  assign off = (block_offset_bits > 4'(tlc_pkg::MAX_OFFSET_BITS)) ?
               4'(tlc_pkg::MAX_OFFSET_BITS) : block_offset_bits;
  assign s1  = (l1_set_bits > 3'(S1W)) ? 3'(S1W) : l1_set_bits;
  assign w1  = (l1_way_bits > 2'(R1W)) ? 2'(R1W) : l1_way_bits;
  assign s2  = (l2_set_bits > 4'(S2W)) ? 4'(S2W) : l2_set_bits;
  assign w2  = l2_way_bits;

  // ---- item, victim address, sweep index ----
  tlc_pkg::access_t acc;
  logic [AW-1:0]    ev_addr;
  logic [S2W-1:0]   clr_idx;
  logic             fill;

  assign fill = !acc.command || write_allocate;

  // ---- address split ----
  logic [AW-1:0]  key1, key2, sh1, sh2, ktag1, ktag2;
  logic [S1W-1:0] kset1;
  logic [S2W-1:0] kset2;

  assign key1  = (cmd.rd_bi || cmd.do_bi) ? ev_addr : acc.address;
  assign key2  = (cmd.rd_wb || cmd.do_wb) ? ev_addr : acc.address;
  assign sh1   = key1 >> off;
  assign sh2   = key2 >> off;
  assign kset1 = sh1[S1W-1:0] & ((S1W'(1) << s1) - S1W'(1));
  assign kset2 = sh2[S2W-1:0] & ((S2W'(1) << s2) - S2W'(1));
  assign ktag1 = key1 >> (5'(off) + 5'(s1));
  assign ktag2 = key2 >> (5'(off) + 5'(s2));

  // ---- memories ----
  l1_row_t r1, w1row;
  l2_row_t r2, w2row;
  logic    we1, we2;
  logic [$bits(l1_row_t)-1:0] r1_raw;
  logic [$bits(l2_row_t)-1:0] r2_raw;

  assign r1 = r1_raw;
  assign r2 = r2_raw;

  tlc_ram #(.WIDTH($bits(l1_row_t)), .DEPTH(tlc_pkg::L1_SETS)) u_l1_ram (
    .clk   (clk),
    .we    (we1),
    .waddr (cmd.clear ? clr_idx[S1W-1:0] : kset1),
    .wdata (w1row),
    .re    (cmd.rd_main || cmd.rd_bi || cmd.rd_v1),
    .raddr (kset1),
    .rdata (r1_raw)
  );

  tlc_ram #(.WIDTH($bits(l2_row_t)), .DEPTH(tlc_pkg::L2_SETS)) u_l2_ram (
    .clk   (clk),
    .we    (we2),
    .waddr (cmd.clear ? clr_idx : kset2),
    .wdata (w2row),
    .re    (cmd.rd_main || cmd.rd_wb),
    .raddr (kset2),
    .rdata (r2_raw)
  );

  // ---- row lookups ----
  logic [R1W:0]   f1;
  logic [R2W:0]   f2;
  logic [R1W-1:0] v1;
  logic [R2W-1:0] v2;

  assign f1 = l1_find(r1, ktag1, w1);
  assign f2 = l2_find(r2, ktag2, w2);
  assign v1 = l1_victim(r1, w1);
  assign v2 = l2_victim(r2, w2);

  always_comb begin
    l1_row_t tmp;
    tmp   = r1;
    w1row = r1;
    we1   = 1'b0;
    if (cmd.clear) begin
      we1 = 1'b1;
      for (int w = 0; w < tlc_pkg::L1_WAYS; w++) begin
        w1row[w] = '{tag: '0, valid: 1'b0, dirty: 1'b0, rank: R1W'(w)};
      end
    end else if (cmd.lookup) begin
      if (f1[R1W]) begin
        we1   = 1'b1;
        w1row = l1_touch(r1, f1[R1W-1:0], w1);
        if (acc.command) w1row[f1[R1W-1:0]].dirty = 1'b1;
      end
    end else if (cmd.do_bi) begin
      if (f1[R1W]) begin
        we1 = 1'b1;
        w1row[f1[R1W-1:0]].valid = 1'b0;
        w1row[f1[R1W-1:0]].dirty = 1'b0;
      end
    end else if (cmd.do_v1) begin
      we1           = 1'b1;
      tmp[v1].tag   = ktag1;
      tmp[v1].valid = 1'b1;
      tmp[v1].dirty = acc.command;
      w1row         = l1_touch(tmp, v1, w1);
    end
  end

  always_comb begin
    l2_row_t tmp;
    tmp   = r2;
    w2row = r2;
    we2   = 1'b0;
    if (cmd.clear) begin
      we2 = 1'b1;
      for (int w = 0; w < tlc_pkg::L2_WAYS; w++) begin
        w2row[w] = '{tag: '0, valid: 1'b0, dirty: 1'b0, rank: R2W'(w)};
      end
    end else if (cmd.lookup) begin
      if (!f1[R1W]) begin
        if (f2[R2W]) begin
          we2   = 1'b1;
          w2row = l2_touch(r2, f2[R2W-1:0], w2);
          if (acc.command) w2row[f2[R2W-1:0]].dirty = 1'b1;
        end else if (fill) begin
          we2           = 1'b1;
          tmp[v2].tag   = ktag2;
          tmp[v2].valid = 1'b1;
          tmp[v2].dirty = acc.command;
          w2row         = l2_touch(tmp, v2, w2);
        end
      end
    end else if (cmd.do_wb) begin
      if (f2[R2W]) begin
        we2 = 1'b1;
        tmp[f2[R2W-1:0]].dirty = 1'b1;
        w2row = l2_touch(tmp, f2[R2W-1:0], w2);
      end
    end
  end

  // ---- registers ----
  logic [tlc_pkg::CNT_W-1:0] cnt [4];
  logic [tlc_pkg::CNT_W-1:0] cnt_next [4];

  always_comb begin
    cnt_next[0] = cnt[0] + 1'b1;
    cnt_next[1] = cnt[1] + tlc_pkg::CNT_W'(!f1[R1W]);
    cnt_next[2] = cnt[2] + tlc_pkg::CNT_W'(!f1[R1W]);
    cnt_next[3] = cnt[3] + tlc_pkg::CNT_W'(!f1[R1W] && !f2[R2W]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
      for (int i = 0; i < 4; i++) cnt[i] <= '0;
    end else begin
      if (cmd.clear) clr_idx <= clr_idx + 1'b1;
      if (cmd.lookup) begin
        for (int i = 0; i < 4; i++) cnt[i] <= cnt_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) acc <= access;
    if (cmd.lookup) begin
      ev_addr <= ((r2[v2].tag << (5'(off) + 5'(s2))) | (AW'(kset2) << off));
      result.l1_hit          <= f1[R1W];
      result.l2_accessed     <= !f1[R1W];
      result.l2_hit          <= !f1[R1W] && f2[R2W];
      result.memory_accessed <= !f1[R1W] && !f2[R2W];
      result.l1_access_total <= cnt_next[0];
      result.l1_miss_total   <= cnt_next[1];
      result.l2_access_total <= cnt_next[2];
      result.l2_miss_total   <= cnt_next[3];
    end else if (cmd.do_v1) begin
      ev_addr <= ((r1[v1].tag << (5'(off) + 5'(s1))) | (AW'(kset1) << off));
    end
  end

  assign status.clr_last     = (clr_idx == '1);
  assign status.l1_hit       = f1[R1W];
  assign status.l2_hit       = f2[R2W];
  assign status.fill         = fill;
  assign status.l2_vic_valid = r2[v2].valid;
  assign status.l1_vic_dirty = r1[v1].valid && r1[v1].dirty;

endmodule

FILE: rtl/core/tlc_controller.sv
`include "two_level_inclusive_lru_cache_core_assert.svh"

module tlc_controller (
  input  logic             clk,
  input  logic             rst,
  input  logic             access_valid,
  output logic             access_ready,
  output logic             result_valid,
  input  logic             result_ready,
  input  tlc_pkg::status_t status,
  output tlc_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_LK    = 4'd3;
  localparam logic [3:0] S_BIRD  = 4'd4;
  localparam logic [3:0] S_BI    = 4'd5;
  localparam logic [3:0] S_V1RD  = 4'd6;
  localparam logic [3:0] S_V1    = 4'd7;
  localparam logic [3:0] S_WBRD  = 4'd8;
  localparam logic [3:0] S_WB    = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign access_ready = (state == S_IDLE);
  assign result_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (access_valid) begin
          cmd.take   = 1'b1;
          state_next = S_RD;
        end
      end
      S_RD: begin
        cmd.rd_main = 1'b1;
        state_next  = S_LK;
      end
      S_LK: begin
        cmd.lookup = 1'b1;
        if (status.l1_hit || !status.fill) state_next = S_OUT;
        else if (!status.l2_hit && status.l2_vic_valid) state_next = S_BIRD;
        else state_next = S_V1RD;
      end
      S_BIRD: begin
        cmd.rd_bi  = 1'b1;
        state_next = S_BI;
      end
      S_BI: begin
        cmd.do_bi  = 1'b1;
        state_next = S_V1RD;
      end
      S_V1RD: begin
        cmd.rd_v1  = 1'b1;
        state_next = S_V1;
      end
      S_V1: begin
        cmd.do_v1  = 1'b1;
        state_next = status.l1_vic_dirty ? S_WBRD : S_OUT;
      end
      S_WBRD: begin
        cmd.rd_wb  = 1'b1;
        state_next = S_WB;
      end
      S_WB: begin
        cmd.do_wb  = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (result_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  `TLC_ASSERT(a_one_read, clk, rst, $onehot0({cmd.rd_main, cmd.rd_bi, cmd.rd_v1, cmd.rd_wb}), "two row reads at once")
  `TLC_ASSERT(a_accept_reads, clk, rst, access_valid && access_ready |=> state == S_RD, "accepted item not read")
  `TLC_ASSERT(a_wb_after_read, clk, rst, state == S_WB |-> $past(state) == S_WBRD, "L2 update without read")

endmodule

FILE: rtl/core/two_level_inclusive_lru_cache_core.sv
// Two-level inclusive set-associative cache tag model with true-LRU ranks.
// access channel (valid/ready): one read or write with a byte address.
// result channel (valid/ready): hit flags for both levels and the four
//   running access and miss counters, one result per access.
// cfg channel (valid/ready, always ready): register index and write data;
//   write only while no access is in flight.
// Timing: one access at a time. On an L1 hit, or a write miss with no
//   allocation, the item goes through the row read and the lookup to the
//   output; a fill adds the L1 re-read and fill, plus back-invalidation
//   and dirty-victim promotion when needed. Each step is one read then
//   one write of a set row in the L1 and L2 tag memories.
// Reset: a clearing sweep writes every L2 set row (and every L1 row)
//   back to its reset content; access_ready stays low meanwhile.
// Stall: the result is held while result_ready is low and no new access is
//   taken until it leaves.
module two_level_inclusive_lru_cache_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             access_valid,
  output logic             access_ready,
  input  tlc_pkg::access_t access,
  output logic             result_valid,
  input  logic             result_ready,
  output tlc_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [3:0]       cfg_data
);

  tlc_pkg::cmd_t    cmd;
  tlc_pkg::status_t status;

  assign cfg_ready = 1'b1;

  tlc_controller u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .access_valid (access_valid),
    .access_ready (access_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .cmd          (cmd)
  );

  tlc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .access    (access),
    .cmd       (cmd),
    .status    (status),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
